[src/text_console_cell_writer_macros.svh]
// Assertion macros shared by the console cell writer modules.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/tccw_pkg.sv]
// Shared constants, types and codes of the text console cell writer.
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  // Fixed channel field widths
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int INDEX_W   = 11;
  localparam int LOC_W     = 11;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  localparam int CELL_W    = 16;

  // White-on-black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam int TAB_STEP = 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_FILL,
    SW_SHIFT,
    SW_BLANK
  } sweep_state_t;

  typedef enum logic {
    C_IDLE,
    C_WAIT
  } ctrl_state_t;

  // Command from the sequencer to the screen memory engine
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic              fill;
    logic              scroll;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } scr_cmd_t;

endpackage

[src/tccw_ifs.sv]
// Valid/ready channel interfaces for requests and results.
interface tccw_in_if;
  import tccw_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] back_color;
  logic [COLOR_W-1:0] fore_color;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, req_type, char_code, back_color, fore_color, cell_index,
                  input ready);
  modport sink (input valid, req_type, char_code, back_color, fore_color, cell_index,
                output ready);
endinterface

interface tccw_out_if;
  import tccw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LOC_W-1:0]     cursor_location;
  logic [CUR_COL_W-1:0] cursor_column;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic                 scrolled;
  logic [CELL_W-1:0]    cell_word;

  modport source (output valid, cursor_location, cursor_column, cursor_row, scrolled,
                  cell_word, input ready);
  modport sink (input valid, cursor_location, cursor_column, cursor_row, scrolled,
                cell_word, output ready);
endinterface

[src/tccw_screen.sv]
// Screen cell memory with its sweep engine for fill and scroll passes.
`include "text_console_cell_writer_macros.svh"

module tccw_screen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tccw_pkg::scr_cmd_t        cmd,
  output logic                      busy,
  output logic [tccw_pkg::CELL_W-1:0] rd_data
);
  import tccw_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW   = ADDR_W'((ROWS - 1) * COLUMNS);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;

  sweep_state_t      sw_state_r, sw_state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic              pend_r, pend_nxt;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  // Sweep sequencer: one cell per cycle through the single write port, except while a pending copy holds it
  always_comb begin
    sw_state_nxt = sw_state_r;
    cnt_nxt      = cnt_r;
    dst_nxt      = dst_r;
    pend_nxt     = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cmd.addr;
    wr_en        = 1'b0;
    wr_addr      = cmd.addr;
    wr_data      = cmd.data;
    unique case (sw_state_r)
      SW_IDLE: begin
        rd_en = cmd.rd;
        wr_en = cmd.wr;
        if (cmd.fill) begin
          cnt_nxt      = '0;
          sw_state_nxt = SW_FILL;
        end else if (cmd.scroll) begin
          cnt_nxt      = ROW_STRIDE;
          sw_state_nxt = SW_SHIFT;
        end
      end
      SW_FILL: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = BLANK_CELL;
        if (cnt_r == LAST_ADDR) begin
          sw_state_nxt = SW_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      SW_SHIFT: begin
        // read one row down, write it one row up from the registered read data
        rd_en    = 1'b1;
        rd_addr  = cnt_r;
        pend_nxt = 1'b1;
        dst_nxt  = cnt_r - ROW_STRIDE;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt      = LAST_ROW;
          sw_state_nxt = SW_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      SW_BLANK: begin
        if (!pend_r) begin
          wr_en   = 1'b1;
          wr_addr = cnt_r;
          wr_data = BLANK_CELL;
          if (cnt_r == LAST_ADDR) begin
            sw_state_nxt = SW_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: sw_state_nxt = SW_IDLE;
    endcase
    // pending copy owns the write port
    if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = dst_r;
      wr_data = rd_data_r;
    end
  end

  // Memory array and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sweep control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_state_r <= SW_FILL;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
    end else begin
      sw_state_r <= sw_state_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r <= dst_nxt;
  end

  assign busy    = (sw_state_r != SW_IDLE);
  assign rd_data = rd_data_r;

  `TCCW_ASSERT_NOW(a_cmd_when_idle, cmd.wr || cmd.rd || cmd.fill || cmd.scroll, sw_state_r == SW_IDLE, "screen command while sweeping")
  `TCCW_ASSERT_NOW(a_pend_dst, pend_r, dst_r < ADDR_W'(CELL_COUNT - COLUMNS), "scroll copy outside upper rows")
  `TCCW_ASSERT_NEXT(a_shift_to_blank, sw_state_r == SW_SHIFT && cnt_r == LAST_ADDR, sw_state_r == SW_BLANK && pend_r, "shift pass did not hand over to blank row")

endmodule

[src/tccw_ctrl.sv]
// Request sequencer: cursor update, screen commands and result register.
`include "text_console_cell_writer_macros.svh"

module tccw_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  tccw_in_if.sink                     in_chan,
  tccw_out_if.source                  out_chan,
  output tccw_pkg::scr_cmd_t          cmd,
  input  logic                        scr_busy,
  input  logic [tccw_pkg::CELL_W-1:0] rd_data
);
  import tccw_pkg::*;

  ctrl_state_t      st_r, st_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             scrolled_r, scrolled_nxt;
  logic             is_read_r, is_read_nxt;

  logic                 out_valid_r;
  logic [LOC_W-1:0]     out_loc_r;
  logic [CUR_COL_W-1:0] out_col_r;
  logic [CUR_ROW_W-1:0] out_row_r;
  logic                 out_scrolled_r;
  logic [CELL_W-1:0]    out_word_r;

  logic              accept;
  logic              load_out;
  logic [ADDR_W-1:0] cur_loc;

  // Cursor as a linear cell address
  assign cur_loc = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);

  assign in_chan.ready = (st_r == C_IDLE) && !scr_busy;
  assign accept        = in_chan.valid && in_chan.ready;
  assign load_out      = (st_r == C_WAIT) && !scr_busy && (!out_valid_r || out_chan.ready);

  // Request decode and cursor arithmetic
  always_comb begin
    logic [COL_W:0] col_t;
    logic [ROW_W:0] row_t;
    logic [COL_W:0] tab_sum;
    st_nxt       = st_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    scrolled_nxt = scrolled_r;
    is_read_nxt  = is_read_r;
    cmd          = '0;
    col_t        = {1'b0, col_r};
    row_t        = {1'b0, row_r};
    tab_sum      = col_t + (COL_W + 1)'(TAB_STEP);
    unique case (st_r)
      C_IDLE: begin
        if (accept) begin
          st_nxt       = C_WAIT;
          scrolled_nxt = 1'b0;
          is_read_nxt  = 1'b0;
          unique case (in_chan.req_type)
            REQ_PUT: begin
              case (in_chan.char_code)
                CH_BS: begin
                  if (col_r != '0) begin
                    col_t = col_t - (COL_W + 1)'(1);
                  end
                end
                CH_TAB: col_t = {tab_sum[COL_W:3], 3'b000};
                CH_CR:  col_t = '0;
                CH_LF: begin
                  col_t = '0;
                  row_t = row_t + (ROW_W + 1)'(1);
                end
                default: begin
                  if (in_chan.char_code >= CH_PRINT_LO && in_chan.char_code <= CH_PRINT_HI) begin
                    cmd.wr   = 1'b1;
                    cmd.addr = cur_loc;
                    cmd.data = {in_chan.back_color, in_chan.fore_color, in_chan.char_code};
                    col_t    = col_t + (COL_W + 1)'(1);
                  end
                end
              endcase
              // wrap past the last column
              if (col_t >= (COL_W + 1)'(COLUMNS)) begin
                col_t = '0;
                row_t = row_t + (ROW_W + 1)'(1);
              end
              // scroll past the last row
              if (row_t >= (ROW_W + 1)'(ROWS)) begin
                row_t        = (ROW_W + 1)'(ROWS - 1);
                cmd.scroll   = 1'b1;
                scrolled_nxt = 1'b1;
              end
              col_nxt = col_t[COL_W-1:0];
              row_nxt = row_t[ROW_W-1:0];
            end
            REQ_CLEAR: begin
              cmd.fill = 1'b1;
              col_nxt  = '0;
              row_nxt  = '0;
            end
            REQ_READ: begin
              if (int'(in_chan.cell_index) < CELL_COUNT) begin
                cmd.rd      = 1'b1;
                cmd.addr    = ADDR_W'(in_chan.cell_index);
                is_read_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      C_WAIT: begin
        if (load_out) begin
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  // Control and cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= C_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item flags and result payload
  always_ff @(posedge clk) begin
    scrolled_r <= scrolled_nxt;
    is_read_r  <= is_read_nxt;
    if (load_out) begin
      out_loc_r      <= LOC_W'(cur_loc);
      out_col_r      <= CUR_COL_W'(col_r);
      out_row_r      <= CUR_ROW_W'(row_r);
      out_scrolled_r <= scrolled_r;
      out_word_r     <= is_read_r ? rd_data : '0;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.cursor_location = out_loc_r;
  assign out_chan.cursor_column   = out_col_r;
  assign out_chan.cursor_row      = out_row_r;
  assign out_chan.scrolled        = out_scrolled_r;
  assign out_chan.cell_word       = out_word_r;

  `TCCW_ASSERT_NOW(a_cursor_range, 1'b1, int'(col_r) < COLUMNS && int'(row_r) < ROWS, "cursor outside screen")
  `TCCW_ASSERT_NEXT(a_accept_to_wait, accept, st_r == C_WAIT, "accepted request not in progress")
  `TCCW_ASSERT_NOW(a_load_only_wait, $rose(out_valid_r), $past(st_r == C_WAIT), "result loaded outside wait state")

endmodule

[src/text_console_cell_writer.sv]
// Channel  | Dir | Fields
// in_chan  | in  | req_type, char_code, back_color, fore_color, cell_index
// out_chan | out | cursor_location, cursor_column, cursor_row, scrolled, cell_word
//
// Put, read and ignored requests: the transfer moves the sequencer to its wait state, the result
// register loads from there once out_chan's slot is free, and in_chan.ready then returns.
// Clear sweeps every cell through the screen memory's single write port.
// Scroll copies rows through the one read and one write port, then blanks the bottom row.
// After reset a clearing pass blanks the screen; in_chan.ready stays low meanwhile.
// One request is in flight at a time; a result waiting on out_chan holds the next result back.
module text_console_cell_writer (
  input logic         clk,
  input logic         rst_n,
  tccw_in_if.sink     in_chan,
  tccw_out_if.source  out_chan
);
  import tccw_pkg::*;

  scr_cmd_t          cmd;
  logic              scr_busy;
  logic [CELL_W-1:0] rd_data;

  // Request sequencer and cursor
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .scr_busy (scr_busy),
    .rd_data  (rd_data)
  );

  // Screen memory and sweep engine
  tccw_screen u_screen (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .busy    (scr_busy),
    .rd_data (rd_data)
  );

endmodule

[tb/sv/console_check_pkg.sv]
// Request/result types and the screen-state scoreboard for the console cell writer bench.
package console_check_pkg;
  import tccw_pkg::*;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] back_color;
    logic [COLOR_W-1:0] fore_color;
    logic [INDEX_W-1:0] cell_index;
  } console_request_t;

  typedef struct packed {
    logic [LOC_W-1:0]     cursor_location;
    logic [CUR_COL_W-1:0] cursor_column;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_word;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen_mem [CELL_COUNT];
    int unsigned       cursor_col;
    int unsigned       cursor_line;
    console_result_t   expected_q [$];
    int unsigned       mismatch_count;
    int unsigned       request_count;
    int unsigned       result_count;
    int unsigned       scroll_count;
    int unsigned       clear_count;
    int unsigned       read_count;
    int unsigned       read_oob_count;

    function new();
      blank_screen();
    endfunction

    function void blank_screen();
      foreach (screen_mem[i]) screen_mem[i] = BLANK_CELL;
      cursor_col  = 0;
      cursor_line = 0;
    endfunction

    // Moves the cursor for one put, writes printable cells, scrolls on overflow.
    function bit apply_put(logic [CHAR_W-1:0] code, logic [7:0] attr);
      int unsigned addr;
      case (code)
        CH_BS:  if (cursor_col > 0) cursor_col--;
        CH_TAB: cursor_col = (cursor_col + TAB_STEP) & ~(TAB_STEP - 1);
        CH_CR:  cursor_col = 0;
        CH_LF: begin
          cursor_col = 0;
          cursor_line++;
        end
        default: begin
          if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
            addr = cursor_line * COLUMNS + cursor_col;
            if (addr < CELL_COUNT) screen_mem[addr] = {attr, code};
            cursor_col++;
          end
        end
      endcase
      if (cursor_col >= COLUMNS) begin
        cursor_col = 0;
        cursor_line++;
      end
      if (cursor_line < ROWS) return 1'b0;
      // shift every row up by one, bottom row goes blank
      for (int unsigned i = 0; i < (ROWS - 1) * COLUMNS; i++)
        screen_mem[i] = screen_mem[i + COLUMNS];
      for (int unsigned i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
        screen_mem[i] = BLANK_CELL;
      cursor_line = ROWS - 1;
      return 1'b1;
    endfunction

    // Accepted request: update the screen copy and queue the expected result.
    function void note_request(console_request_t r);
      console_result_t want;
      want = '0;
      request_count++;
      case (r.req_type)
        REQ_PUT: begin
          want.scrolled = apply_put(r.char_code, {r.back_color, r.fore_color});
          if (want.scrolled) scroll_count++;
        end
        REQ_CLEAR: begin
          blank_screen();
          clear_count++;
        end
        REQ_READ: begin
          read_count++;
          if (r.cell_index < CELL_COUNT) want.cell_word = screen_mem[r.cell_index];
          else read_oob_count++;
        end
        default: ;
      endcase
      want.cursor_location = LOC_W'(cursor_line * COLUMNS + cursor_col);
      want.cursor_column   = CUR_COL_W'(cursor_col);
      want.cursor_row      = CUR_ROW_W'(cursor_line);
      expected_q.push_back(want);
    endfunction

    function string fmt_result(console_result_t r);
      return $sformatf("loc %0d col %0d row %0d scrolled %0b cell %h",
                       r.cursor_location, r.cursor_column, r.cursor_row,
                       r.scrolled, r.cell_word);
    endfunction

    // Accepted result: compare field by field with the oldest expectation.
    function void check_result(console_result_t got);
      console_result_t want;
      result_count++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %0d: %s", result_count, fmt_result(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.cursor_location !== want.cursor_location ||
          got.cursor_column !== want.cursor_column ||
          got.cursor_row !== want.cursor_row ||
          got.scrolled !== want.scrolled ||
          got.cell_word !== want.cell_word) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d wrong: expected %s, got %s", result_count,
                   fmt_result(want), fmt_result(got));
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

[tb/sv/testbench.sv]
// Top-level bench: drives console requests, checks every result against the screen scoreboard.
module testbench;
  import tccw_pkg::*;
  import console_check_pkg::*;

  localparam int unsigned IDLE_PCT       = 7;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_AFTER     = 100;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned RANDOM_ITEMS   = 450;
  localparam int unsigned SEGMENT_ITEMS  = 75;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        no_idle;
  logic        held_off = 1'b0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;

  console_scoreboard board = new();

  tccw_in_if  in_chan ();
  tccw_out_if out_chan ();

  text_console_cell_writer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  function automatic console_request_t build_request(logic [REQ_W-1:0] kind,
                                                     logic [CHAR_W-1:0] code,
                                                     logic [COLOR_W-1:0] back,
                                                     logic [COLOR_W-1:0] fore,
                                                     logic [INDEX_W-1:0] index);
    console_request_t r;
    r.req_type   = kind;
    r.char_code  = code;
    r.back_color = back;
    r.fore_color = fore;
    r.cell_index = index;
    return r;
  endfunction

  // Line feed share of puts per segment; one segment runs long lines that wrap.
  function automatic int unsigned lf_weight(int unsigned seg);
    case (seg)
      3:       return 3;
      5:       return 10;
      default: return 25;
    endcase
  endfunction

  // Mostly text with line feeds, some reads near the cursor, a little noise.
  function automatic console_request_t random_request(int unsigned lf_pct);
    console_request_t r;
    int unsigned      pick;
    int unsigned      base_row;
    r = build_request(REQ_PUT, CHAR_W'($urandom_range(255)), COLOR_W'($urandom_range(15)),
                      COLOR_W'($urandom_range(15)), INDEX_W'($urandom_range(2047)));
    pick = $urandom_range(99);
    if (pick < 2) begin
      r.req_type = REQ_UNUSED;
    end else if (pick < 22) begin
      r.req_type = REQ_READ;
      pick = $urandom_range(99);
      if (pick < 50) begin
        base_row = board.cursor_line;
        if (base_row > 0 && $urandom_range(1)) base_row--;
        r.cell_index = INDEX_W'(base_row * COLUMNS + $urandom_range(COLUMNS - 1));
      end else if (pick < 90) begin
        r.cell_index = INDEX_W'($urandom_range(CELL_COUNT - 1));
      end
    end else if ($urandom_range(99) < lf_pct) begin
      r.char_code = CH_LF;
    end else begin
      pick = $urandom_range(99);
      if (pick < 60) r.char_code = CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
      else if (pick < 68) r.char_code = CH_TAB;
      else if (pick < 76) r.char_code = CH_BS;
      else if (pick < 82) r.char_code = CH_CR;
      else if (pick < 91) begin
        do r.char_code = CHAR_W'($urandom_range(31));
        while (r.char_code inside {CH_BS, CH_TAB, CH_LF, CH_CR});
      end else r.char_code = CHAR_W'($urandom_range(255, 128));
    end
    return r;
  endfunction

  // Offer one request, with random idle cycles first; returns once in_chan.ready is seen high after an edge.
  task automatic send_request(console_request_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= r.req_type;
    in_chan.char_code  <= r.char_code;
    in_chan.back_color <= r.back_color;
    in_chan.fore_color <= r.fore_color;
    in_chan.cell_index <= r.cell_index;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Field extremes, every request kind, control codes and ignored bytes.
  task automatic run_directed();
    send_request(build_request(REQ_READ, 8'h00, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_READ, 8'hFF, 4'hF, 4'hF, 11'd1999));
    send_request(build_request(REQ_READ, 8'h00, 4'h0, 4'h0, 11'd2000));
    send_request(build_request(REQ_READ, 8'h00, 4'h0, 4'h0, 11'd2047));
    send_request(build_request(REQ_UNUSED, 8'hFF, 4'hF, 4'hF, 11'd2047));
    send_request(build_request(REQ_PUT, 8'h41, 4'hF, 4'hF, 11'd0));
    send_request(build_request(REQ_PUT, CH_PRINT_LO, 4'h0, 4'h0, 11'd2047));
    send_request(build_request(REQ_PUT, CH_PRINT_HI, 4'hA, 4'h5, 11'd0));
    send_request(build_request(REQ_PUT, CH_BS, 4'h3, 4'hC, 11'd0));
    send_request(build_request(REQ_READ, 8'h00, 4'h0, 4'h0, 11'd2));
    send_request(build_request(REQ_PUT, CH_CR, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_PUT, CH_BS, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_PUT, CH_TAB, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_PUT, CH_TAB, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_PUT, 8'h80, 4'h1, 4'h2, 11'd0));
    send_request(build_request(REQ_PUT, 8'hFF, 4'hF, 4'hF, 11'd0));
    send_request(build_request(REQ_PUT, 8'h00, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_PUT, 8'h1F, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_PUT, 8'h0C, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_PUT, CH_LF, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_READ, 8'h00, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_READ, 8'h00, 4'h0, 4'h0, 11'd1));
    send_request(build_request(REQ_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0));
    send_request(build_request(REQ_READ, 8'h00, 4'h0, 4'h0, 11'd0));
  endtask

  // Monitor both channels at each edge; also counts edges without any transfer.
  always @(posedge clk) begin : monitor
    console_request_t seen_req;
    console_result_t  seen_res;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        seen_req.req_type   = in_chan.req_type;
        seen_req.char_code  = in_chan.char_code;
        seen_req.back_color = in_chan.back_color;
        seen_req.fore_color = in_chan.fore_color;
        seen_req.cell_index = in_chan.cell_index;
        board.note_request(seen_req);
      end
      if (out_chan.valid && out_chan.ready) begin
        seen_res.cursor_location = out_chan.cursor_location;
        seen_res.cursor_column   = out_chan.cursor_column;
        seen_res.cursor_row      = out_chan.cursor_row;
        seen_res.scrolled        = out_chan.scrolled;
        seen_res.cell_word       = out_chan.cell_word;
        board.check_result(seen_res);
        results_seen <= results_seen + 1;
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random backpressure plus one long hold-off to fill the block.
  initial begin : result_sink
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !held_off && results_seen >= HOLD_AFTER) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      out_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("no transfer for %0d cycles, %0d results outstanding",
             stall_cycles, board.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_flow
    int unsigned seg;
    rst_n              <= 1'b0;
    no_idle            <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.req_type   <= REQ_PUT;
    in_chan.char_code  <= '0;
    in_chan.back_color <= '0;
    in_chan.fore_color <= '0;
    in_chan.cell_index <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // random segments; clears only at some segment starts so the cursor reaches the bottom
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      seg = i / SEGMENT_ITEMS;
      if (i % SEGMENT_ITEMS == 0) begin
        no_idle <= (seg == 2);
        if (seg == 2 || seg == 4)
          send_request(build_request(REQ_CLEAR, CHAR_W'($urandom_range(255)),
                                     COLOR_W'($urandom_range(15)),
                                     COLOR_W'($urandom_range(15)),
                                     INDEX_W'($urandom_range(2047))));
      end
      send_request(random_request(lf_weight(seg)));
    end
    in_chan.valid <= 1'b0;

    // let the monitor note the last transfer before polling the queue
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results: %0d scrolls, %0d clears",
             board.request_count, board.result_count, board.scroll_count, board.clear_count);
    $display("%0d reads, %0d of them past the last cell; %0d mismatches",
             board.read_count, board.read_oob_count, board.mismatch_count);
    if (board.mismatch_count == 0 && board.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/tccw_pkg.sv
src/tccw_ifs.sv
src/tccw_screen.sv
src/tccw_ctrl.sv
src/text_console_cell_writer.sv
tb/sv/console_check_pkg.sv
tb/sv/testbench.sv
